// ----- rtl/vtm_pkg.sv -----
// Shared types and constants for the virtual timer multiplexer.
`default_nettype none
package vtm_pkg;
    localparam int unsigned TIMER_COUNT = 8;
    localparam int unsigned IDX_W = 3;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_STOP    = 2'd1;
    localparam logic [1:0] OP_ELAPSE  = 2'd2;
    localparam logic [1:0] OP_DEQUEUE = 2'd3;

    localparam logic [1:0] KIND_REPEAT  = 2'd0;
    localparam logic [1:0] KIND_ONESHOT = 2'd1;

    localparam logic       CFG_MAX_INTERVAL = 1'b0;
    localparam logic       CFG_MIN_LEAD     = 1'b1;

    localparam logic [7:0] MAX_INTERVAL_RST = 8'd230;
    localparam logic [3:0] MIN_LEAD_RST     = 4'd3;
    localparam logic [3:0] ID_EMPTY         = 4'd8;
    localparam logic signed [31:0] FIRE_LEVEL = 32'sd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  timer_id;
        logic [1:0]  timer_kind;
        logic [30:0] period;
        logic [7:0]  counter_now;
        logic [15:0] elapsed;
        logic [3:0]  post_credit;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  fired_mask;
        logic [3:0]  dequeued_id;
        logic [7:0]  next_interval;
        logic [7:0]  active_mask;
        logic        queue_overflow;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUB,
        ST_RESOLVE,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic sub;
        logic resolve;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       last_slot;
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/vtm_req_if.sv -----
// Request channel: one operation word per handshake.
`default_nettype none
interface vtm_req_if;
    logic           valid;
    logic           ready;
    vtm_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/vtm_rsp_if.sv -----
// Response channel: one result word per handshake.
`default_nettype none
interface vtm_rsp_if;
    logic           valid;
    logic           ready;
    vtm_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/virtual_timer_multiplexer.sv -----
// Top level: software timer bank multiplexed onto one compare counter.
// Start, stop and dequeue pass through the exec and done states; done loads the result
// once the output register is free. Elapse runs exec, then subtract and resolve for each
// timer slot in turn, then finish and done.
// One operation is in work at a time; a result may wait while the next word is taken.
// Synchronous active-low reset clears timers, fired-id queue and registers to defaults.
`default_nettype none
module virtual_timer_multiplexer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    vtm_req_if.sink         i_req,
    vtm_rsp_if.source       o_rsp
);
    vtm_pkg::t_cmd  cmd;
    vtm_pkg::t_stat stat;

    vtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    vtm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_rsp      (o_rsp.data)
    );

    a_fail_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status |-> o_rsp.data.fired_mask == 8'd0
            && !o_rsp.data.queue_overflow)
        else $error("failed start/stop reported elapse activity");

    a_deq_only_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.dequeued_id != vtm_pkg::ID_EMPTY
            |-> o_rsp.data.fired_mask == 8'd0 && !o_rsp.data.status
            && o_rsp.data.dequeued_id < vtm_pkg::ID_EMPTY)
        else $error("dequeue result mixed with other activity");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("controller issued overlapping commands");
endmodule
`default_nettype wire

// ----- rtl/vtm_ctrl.sv -----
// Sequencing state machine for the timer multiplexer.
`default_nettype none
module vtm_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    input  vtm_pkg::t_stat    i_stat,
    output vtm_pkg::t_cmd     o_cmd
);
    vtm_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vtm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vtm_pkg::ST_IDLE:    if (i_in_valid) n_state = vtm_pkg::ST_EXEC;
            vtm_pkg::ST_EXEC: begin
                if (i_stat.op == vtm_pkg::OP_ELAPSE) n_state = vtm_pkg::ST_SUB;
                else n_state = vtm_pkg::ST_DONE;
            end
            vtm_pkg::ST_SUB:     n_state = vtm_pkg::ST_RESOLVE;
            vtm_pkg::ST_RESOLVE: begin
                if (i_stat.last_slot) n_state = vtm_pkg::ST_FINISH;
                else n_state = vtm_pkg::ST_SUB;
            end
            vtm_pkg::ST_FINISH:  n_state = vtm_pkg::ST_DONE;
            vtm_pkg::ST_DONE:    if (out_free) n_state = vtm_pkg::ST_IDLE;
            default:             n_state = vtm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            vtm_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            vtm_pkg::ST_EXEC:    o_cmd.exec    = 1'b1;
            vtm_pkg::ST_SUB:     o_cmd.sub     = 1'b1;
            vtm_pkg::ST_RESOLVE: o_cmd.resolve = 1'b1;
            vtm_pkg::ST_FINISH:  o_cmd.finish  = 1'b1;
            vtm_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/vtm_dp.sv -----
// Timer bank, fired-id ring and interval logic.
`default_nettype none
module vtm_dp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  vtm_pkg::t_cmd     i_cmd,
    input  vtm_pkg::t_req     i_req,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [7:0]   i_cfg_data,
    output vtm_pkg::t_stat    o_stat,
    output vtm_pkg::t_rsp     o_rsp
);
    localparam int unsigned N = vtm_pkg::TIMER_COUNT;
    localparam int unsigned W = vtm_pkg::IDX_W;

    vtm_pkg::t_req r_req;
    logic [7:0]  r_max_interval, r_cmp_interval;
    logic [3:0]  r_min_lead;
    logic [N-1:0] r_running;
    logic        r_repeat [N];
    logic [30:0] r_reload [N];
    logic signed [31:0] r_ticks [N];
    logic [W-1:0] r_ring [N];
    logic [W-1:0] r_head, r_tail, r_idx;
    logic [3:0]  r_count, r_credit;
    logic signed [31:0] r_t;
    logic [7:0]  r_best;
    logic        r_status, r_overflow;
    logic [7:0]  r_fired;
    logic [3:0]  r_deq;
    vtm_pkg::t_rsp r_rsp;

    logic [W-1:0] sid;
    logic         start_bad;
    logic [31:0]  total;
    logic signed [32:0] diff, reload_sum;
    logic signed [31:0] sub_t, res_t;
    logic         res_run, push;
    logic [7:0]   lead, fin_best;

    assign sid = r_req.timer_id[W-1:0];
    assign start_bad = (r_req.timer_id >= 8'(N)) || (r_req.timer_kind > vtm_pkg::KIND_ONESHOT)
        || (r_req.timer_kind == vtm_pkg::KIND_REPEAT && r_req.period <= 31'd2);
    assign total = {1'b0, r_req.period} + {24'd0, r_req.counter_now};

    assign diff = {r_ticks[r_idx][31], r_ticks[r_idx]} - $signed({17'd0, r_req.elapsed});
    assign sub_t = (diff < -33'sh0_8000_0000) ? 32'sh8000_0000 : diff[31:0];

    assign reload_sum = {r_t[31], r_t} + $signed({2'b00, r_reload[r_idx]});

    always_comb begin
        res_t   = r_t;
        res_run = 1'b1;
        push    = 1'b0;
        if (r_t <= vtm_pkg::FIRE_LEVEL) begin
            if (r_credit != 4'd0) begin
                push = 1'b1;
                if (r_repeat[r_idx])
                    res_t = (reload_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : reload_sum[31:0];
                else
                    res_run = 1'b0;
            end else begin
                res_t = $signed({24'd0, r_cmp_interval});
            end
        end
    end

    assign lead = r_req.counter_now + {4'd0, r_min_lead};
    assign fin_best = (r_best < lead) ? lead : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_interval <= vtm_pkg::MAX_INTERVAL_RST;
            r_min_lead     <= vtm_pkg::MIN_LEAD_RST;
            r_cmp_interval <= vtm_pkg::MAX_INTERVAL_RST;
            r_running      <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_idx          <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vtm_pkg::CFG_MAX_INTERVAL) r_max_interval <= i_cfg_data;
                else r_min_lead <= i_cfg_data[3:0];
            end
            if (i_cmd.exec) begin
                r_idx <= '0;
                case (r_req.op)
                    vtm_pkg::OP_START: if (!start_bad) begin
                        r_running[sid] <= 1'b1;
                        if (total < {24'd0, r_cmp_interval}) r_cmp_interval <= total[7:0];
                    end
                    vtm_pkg::OP_STOP:
                        if (r_req.timer_id < 8'(N) && r_running[sid]) r_running[sid] <= 1'b0;
                    vtm_pkg::OP_DEQUEUE: if (r_count != 4'd0) begin
                        r_head  <= r_head + 1'b1;
                        r_count <= r_count - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.resolve) begin
                r_idx <= r_idx + 1'b1;
                if (r_running[r_idx]) begin
                    r_running[r_idx] <= res_run;
                    if (push && r_count < 4'(N)) begin
                        r_tail  <= r_tail + 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_cmp_interval <= (r_running == '0) ? r_max_interval : fin_best;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_req <= i_req;
        if (i_cmd.exec) begin
            r_status   <= 1'b0;
            r_fired    <= '0;
            r_overflow <= 1'b0;
            r_deq      <= vtm_pkg::ID_EMPTY;
            r_credit   <= r_req.post_credit;
            r_best     <= r_max_interval;
            case (r_req.op)
                vtm_pkg::OP_START: begin
                    if (start_bad) r_status <= 1'b1;
                    else begin
                        r_reload[sid] <= r_req.period;
                        r_repeat[sid] <= (r_req.timer_kind == vtm_pkg::KIND_REPEAT);
                        r_ticks[sid]  <= total[31] ? 32'sh7FFF_FFFF : $signed(total);
                    end
                end
                vtm_pkg::OP_STOP:
                    if (!(r_req.timer_id < 8'(N) && r_running[sid])) r_status <= 1'b1;
                vtm_pkg::OP_DEQUEUE:
                    if (r_count != 4'd0) r_deq <= {1'b0, r_ring[r_head]};
                default: ;
            endcase
        end
        if (i_cmd.sub) r_t <= sub_t;
        if (i_cmd.resolve && r_running[r_idx]) begin
            r_ticks[r_idx] <= res_t;
            if (push) begin
                r_credit <= r_credit - 1'b1;
                if (r_count < 4'(N)) begin
                    r_ring[r_tail] <= r_idx;
                    r_fired[r_idx] <= 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            // running minimum, negative counts floor at zero
            if (res_run && res_t < $signed({24'd0, r_best}))
                r_best <= res_t[31] ? 8'd0 : res_t[7:0];
        end
        if (i_cmd.load_out) begin
            r_rsp.status         <= r_status;
            r_rsp.fired_mask     <= r_fired;
            r_rsp.dequeued_id    <= r_deq;
            r_rsp.next_interval  <= r_cmp_interval;
            r_rsp.active_mask    <= r_running;
            r_rsp.queue_overflow <= r_overflow;
        end
    end

    assign o_stat.op        = r_req.op;
    assign o_stat.last_slot = (r_idx == W'(N - 1));
    assign o_rsp            = r_rsp;
endmodule
`default_nettype wire
